[hw/rtl/sralm_pkg.sv]
// ----------------------------------------------------------------------------
// sralm_pkg
// Shared widths, iteration counts and the controller state type of the range
// multilook accumulator.
// ----------------------------------------------------------------------------
package sralm_pkg;

  localparam int SMP_W  = 16;  // sample component width
  localparam int COL_W  = 16;  // column field width
  localparam int ROW_W  = 8;   // row field width
  localparam int GAIN_W = 16;  // scallop gain width, unsigned Q2.14
  localparam int PWR_W  = 32;  // power of one sample
  localparam int SUM_W  = 40;  // saturating power sum
  localparam int CNT_W  = 8;   // saturating look count
  localparam int ROOT_W = 20;  // integer square root of the mean
  localparam int REM_W  = 22;  // square root partial remainder
  localparam int PROD_W = ROOT_W + GAIN_W;
  localparam int MAG_W  = 18;  // output magnitude
  localparam int FRAC_W = 14;  // fraction bits of the gain

  // Bits retired per clock by every serial unit.
  localparam int STEPS = 2;

  localparam int SQ_CYC   = SMP_W / STEPS;
  localparam int DIV_CYC  = SUM_W / STEPS;
  localparam int SQRT_CYC = ROOT_W / STEPS;
  localparam int MUL_CYC  = GAIN_W / STEPS;
  localparam int IT_W     = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_ACC_SQ  = 9'b000000100,
    S_ACC_WB  = 9'b000001000,
    S_RD_WAIT = 9'b000010000,
    S_RD_CHK  = 9'b000100000,
    S_RD_DIV  = 9'b001000000,
    S_RD_SQRT = 9'b010000000,
    S_RD_MUL  = 9'b100000000
  } sralm_state_e;

endpackage

[hw/rtl/sar_range_multilook_accumulator_core.sv]
// ----------------------------------------------------------------------------
// sar_range_multilook_accumulator_core
// Multilook power accumulator with serial square, divide, root and gain units.
// ----------------------------------------------------------------------------
// Usage. A command is transferred at a rising edge where start is high and
// busy is low. With kind_i low the command adds the power of the complex
// sample to the sum of pixel (column_i, row_i); a sample on row 0 also starts
// a new look for that column. Accumulates outside the image are dropped.
// With kind_i high the command reads one pixel and returns exactly one result
// on magnitude_o/no_looks_o, shown for a single cycle with valid_o high.
// The receiver cannot stall; every result must be taken in that cycle.
// Timing. The power is formed by two squarers retiring two multiplier bits a
// cycle, and an accumulate keeps busy high until the sum is written back.
// A read runs a two-bit-per-cycle restoring divider, a two-bit root
// extractor and a two-bit gain multiplier in turn; busy falls in the cycle
// in which its result appears. A read of a column without looks returns
// once the look count is checked, a read outside the image straight from
// idle. No command is taken while busy, so the serial read chain sets the pace.
// Reset. After rst_ni is released the block sweeps both memories to zero,
// one entry per cycle, over all COLUMNS*ROWS addresses (16384 by default)
// with busy held high; no command is taken during that pass.
// ----------------------------------------------------------------------------
module sar_range_multilook_accumulator_core #(
  parameter int COLUMNS = 64,
  parameter int ROWS    = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind_i,
  input  logic signed [sralm_pkg::COL_W-1:0]  column_i,
  input  logic [sralm_pkg::ROW_W-1:0]         row_i,
  input  logic signed [sralm_pkg::SMP_W-1:0]  sample_real_i,
  input  logic signed [sralm_pkg::SMP_W-1:0]  sample_imag_i,
  input  logic [sralm_pkg::GAIN_W-1:0]        scallop_gain_i,
  output logic                                valid_o,
  output logic [sralm_pkg::MAG_W-1:0]         magnitude_o,
  output logic                                no_looks_o
);

  import sralm_pkg::*;

  localparam int Depth = COLUMNS * ROWS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Control state.
  sralm_state_e       state_q, state_d;
  logic [IT_W-1:0]    it_q, it_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               valid_q, valid_d;

  // Command and datapath registers.
  logic [AW-1:0]      addr_q;
  logic [CW-1:0]      col_q;
  logic               row0_q;
  logic [SMP_W-1:0]   ar_q, ai_q;
  logic [PWR_W-1:0]   pr_q, pi_q, pr_n, pi_n;
  logic [GAIN_W-1:0]  gain_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   dq_q, dq_n, rad_n;
  logic [CNT_W-1:0]   drem_q, drem_n;
  logic [REM_W-1:0]   srem_q, srem_n;
  logic [ROOT_W-1:0]  sroot_q, sroot_n;
  logic [PROD_W-1:0]  mp_q, mp_n;
  logic [MAG_W-1:0]   mag_q;
  logic               nolooks_q;

  // Memory ports.
  logic               clearing;
  logic               sum_we, cnt_we;
  logic [AW-1:0]      sum_addr;
  logic [CW-1:0]      cnt_addr;
  logic [SUM_W-1:0]   sum_wdata, sum_rdata, sum_new;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata, cnt_new;
  logic [SUM_W:0]     sum_wide;

  logic               in_valid;
  logic [SMP_W-1:0]   abs_r, abs_i;

  // Magnitude of a two's complement sample; the most negative value maps to
  // 2^15, which still fits the unsigned width.
  function automatic logic [SMP_W-1:0] abs16(input logic [SMP_W-1:0] x);
    return x[SMP_W-1] ? SMP_W'(~x + SMP_W'(1)) : x;
  endfunction

  assign abs_r    = abs16(sample_real_i);
  assign abs_i    = abs16(sample_imag_i);
  assign in_valid = (32'($unsigned(column_i)) < COLUMNS) && (32'(row_i) < ROWS);

  // --------------------------------------------------------------------------
  // Memories. The sum store holds one entry per pixel, the count store one
  // entry per column; both are swept to zero after reset.
  // --------------------------------------------------------------------------
  assign clearing  = (state_q == S_CLEAR);
  assign sum_wide  = {1'b0, sum_rdata} + (SUM_W + 1)'(pr_q + pi_q);
  assign sum_new   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign cnt_new   = (row0_q && (cnt_rdata != CNT_MAX)) ? cnt_rdata + CNT_W'(1) : cnt_rdata;

  assign sum_addr  = clearing ? clr_q : addr_q;
  assign sum_we    = clearing || (state_q == S_ACC_WB);
  assign sum_wdata = clearing ? '0 : sum_new;

  assign cnt_addr  = clearing ? clr_q[CW-1:0] : col_q;
  assign cnt_we    = (clearing && (32'(clr_q) < COLUMNS)) || (state_q == S_ACC_WB);
  assign cnt_wdata = clearing ? '0 : cnt_new;

  sralm_ram #(
    .Width (SUM_W),
    .Depth (Depth)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (sum_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  sralm_ram #(
    .Width (CNT_W),
    .Depth (COLUMNS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  // --------------------------------------------------------------------------
  // Serial units. Each retires STEPS bits per cycle.
  // --------------------------------------------------------------------------

  // Shift-add squarers for both sample components.
  always_comb begin : sq_comb
    logic [SMP_W:0] up_r;
    logic [SMP_W:0] up_i;
    pr_n = pr_q;
    pi_n = pi_q;
    for (int k = 0; k < STEPS; k++) begin
      up_r = {1'b0, pr_n[PWR_W-1:SMP_W]} + (pr_n[0] ? {1'b0, ar_q} : '0);
      pr_n = {up_r, pr_n[SMP_W-1:1]};
      up_i = {1'b0, pi_n[PWR_W-1:SMP_W]} + (pi_n[0] ? {1'b0, ai_q} : '0);
      pi_n = {up_i, pi_n[SMP_W-1:1]};
    end
  end

  // Restoring divider: the dividend shifts out of dq at the top while the
  // quotient bits shift in at the bottom.
  always_comb begin : div_comb
    logic [CNT_W:0] r9;
    dq_n   = dq_q;
    drem_n = drem_q;
    for (int k = 0; k < STEPS; k++) begin
      r9 = {drem_n, dq_n[SUM_W-1]};
      if (r9 >= {1'b0, cnt_q}) begin
        drem_n = CNT_W'(r9 - {1'b0, cnt_q});
        dq_n   = {dq_n[SUM_W-2:0], 1'b1};
      end else begin
        drem_n = r9[CNT_W-1:0];
        dq_n   = {dq_n[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Digit-by-digit square root, one radicand bit pair per step.
  always_comb begin : sqrt_comb
    logic [REM_W+1:0] r24;
    logic [REM_W+1:0] t24;
    rad_n   = dq_q;
    srem_n  = srem_q;
    sroot_n = sroot_q;
    for (int k = 0; k < STEPS; k++) begin
      r24   = {srem_n, rad_n[SUM_W-1:SUM_W-2]};
      t24   = {2'b00, sroot_n, 2'b01};
      rad_n = {rad_n[SUM_W-3:0], 2'b00};
      if (r24 >= t24) begin
        srem_n  = REM_W'(r24 - t24);
        sroot_n = {sroot_n[ROOT_W-2:0], 1'b1};
      end else begin
        srem_n  = r24[REM_W-1:0];
        sroot_n = {sroot_n[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Shift-add gain multiplier; the gain sits in the low half of the product.
  always_comb begin : mul_comb
    logic [ROOT_W:0] up;
    mp_n = mp_q;
    for (int k = 0; k < STEPS; k++) begin
      up   = {1'b0, mp_n[PROD_W-1:GAIN_W]} + (mp_n[0] ? {1'b0, sroot_q} : '0);
      mp_n = {up, mp_n[GAIN_W-1:1]};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    clr_d   = clr_q;
    valid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(Depth - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          if (kind_i) begin
            if (in_valid) begin
              state_d = S_RD_WAIT;
            end else begin
              valid_d = 1'b1;
            end
          end else if (in_valid) begin
            state_d = S_ACC_SQ;
            it_d    = IT_W'(SQ_CYC - 1);
          end
        end
      end
      S_ACC_SQ: begin
        if (it_q == '0) begin
          state_d = S_ACC_WB;
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end
      S_ACC_WB: begin
        state_d = S_IDLE;
      end
      S_RD_WAIT: begin
        state_d = S_RD_CHK;
      end
      S_RD_CHK: begin
        if (cnt_rdata == '0) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RD_DIV;
          it_d    = IT_W'(DIV_CYC - 1);
        end
      end
      S_RD_DIV: begin
        if (it_q == '0) begin
          state_d = S_RD_SQRT;
          it_d    = IT_W'(SQRT_CYC - 1);
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end
      S_RD_SQRT: begin
        if (it_q == '0) begin
          state_d = S_RD_MUL;
          it_d    = IT_W'(MUL_CYC - 1);
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end
      S_RD_MUL: begin
        if (it_q == '0) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          it_d = it_q - IT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      it_q    <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers carry no reset; the sequencer qualifies their use.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_q    <= AW'(32'(column_i[CW-1:0]) * ROWS + 32'(row_i));
          col_q     <= column_i[CW-1:0];
          row0_q    <= (row_i == '0);
          ar_q      <= abs_r;
          ai_q      <= abs_i;
          pr_q      <= PWR_W'(abs_r);
          pi_q      <= PWR_W'(abs_i);
          gain_q    <= scallop_gain_i;
          mag_q     <= '0;
          nolooks_q <= 1'b1;
        end
      end
      S_ACC_SQ: begin
        pr_q <= pr_n;
        pi_q <= pi_n;
      end
      S_RD_CHK: begin
        cnt_q   <= cnt_rdata;
        dq_q    <= sum_rdata;
        drem_q  <= '0;
        srem_q  <= '0;
        sroot_q <= '0;
        mp_q    <= PROD_W'(gain_q);
      end
      S_RD_DIV: begin
        dq_q   <= dq_n;
        drem_q <= drem_n;
      end
      S_RD_SQRT: begin
        dq_q    <= rad_n;
        srem_q  <= srem_n;
        sroot_q <= sroot_n;
      end
      S_RD_MUL: begin
        mp_q <= mp_n;
        if (it_q == '0) begin
          mag_q     <= (|mp_n[PROD_W-1:FRAC_W+MAG_W]) ? '1 : mp_n[FRAC_W+MAG_W-1:FRAC_W];
          nolooks_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign magnitude_o = mag_q;
  assign no_looks_o  = nolooks_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_nolooks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && no_looks_o) |-> (magnitude_o == '0))
    else $error("no-looks result with nonzero magnitude");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == S_RD_CHK) || ($past(state_q) == S_RD_MUL) ||
                (($past(state_q) == S_IDLE) && $past(start) && $past(kind_i)))
    else $error("result strobe without a read command behind it");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DIV) |-> (drem_q < cnt_q))
    else $error("divider remainder not below the look count");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_SQRT) |-> (REM_W'(srem_q) <= {1'b0, sroot_q, 1'b0}))
    else $error("root remainder exceeds twice the partial root");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (busy && !valid_o))
    else $error("command window open during the clearing pass");

endmodule

[hw/rtl/sralm_ram.sv]
// ----------------------------------------------------------------------------
// sralm_ram
// Generic single-port RAM with one write or read address per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module sralm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range multilook power accumulator. A driver
// feeds accumulate and read commands from a queue, an in-bench model of the
// power store and look counters predicts each read, and a monitor compares
// every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sralm_pkg::*;

  localparam int NUM_COLS    = 64;
  localparam int NUM_ROWS    = 256;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYC  = 60;

  // Command kinds.
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [SUM_W-1:0] SUM_SAT   = '1;
  localparam logic [MAG_W-1:0] MAG_SAT   = '1;
  localparam logic [CNT_W-1:0] LOOKS_SAT = '1;
  localparam int               GAIN_ONE  = 1 << FRAC_W;

  typedef struct packed {
    logic                    kind;
    logic signed [COL_W-1:0] column;
    logic [ROW_W-1:0]        row;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    logic [GAIN_W-1:0]       gain;
  } pixel_cmd_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             no_looks;
  } pixel_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic                    kind_i         = KIND_ACC;
  logic signed [COL_W-1:0] column_i       = '0;
  logic [ROW_W-1:0]        row_i          = '0;
  logic signed [SMP_W-1:0] sample_real_i  = '0;
  logic signed [SMP_W-1:0] sample_imag_i  = '0;
  logic [GAIN_W-1:0]       scallop_gain_i = '0;
  logic                    valid_o;
  logic [MAG_W-1:0]        magnitude_o;
  logic                    no_looks_o;

  // Commands still to be sent and read results still to arrive.
  pixel_cmd_t    pending_cmds[$];
  pixel_result_t awaited_pixels[$];

  // Bench copy of the power store and the per-column look counters.
  logic [SUM_W-1:0] pix_power [NUM_COLS*NUM_ROWS];
  logic [CNT_W-1:0] look_cnt  [NUM_COLS];

  int gap_pct    = 0;
  int mismatches = 0;
  int cycle_cnt  = 0;

  always #6 clk_i = ~clk_i;

  sar_range_multilook_accumulator_core #(
    .COLUMNS (NUM_COLS),
    .ROWS    (NUM_ROWS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .sample_real_i  (sample_real_i),
    .sample_imag_i  (sample_imag_i),
    .scallop_gain_i (scallop_gain_i),
    .valid_o        (valid_o),
    .magnitude_o    (magnitude_o),
    .no_looks_o     (no_looks_o)
  );

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic pixel_cmd_t make_cmd(input logic k, input int col, input int row,
                                          input int re, input int im, input int gain);
    pixel_cmd_t c;
    c.kind   = k;
    c.column = col[COL_W-1:0];
    c.row    = row[ROW_W-1:0];
    c.re     = re[SMP_W-1:0];
    c.im     = im[SMP_W-1:0];
    c.gain   = gain[GAIN_W-1:0];
    return c;
  endfunction

  function automatic longint sample_power(input logic signed [SMP_W-1:0] x);
    longint m;
    m = x;
    if (m < 0) begin
      m = -m;
    end
    return m * m;
  endfunction

  // Applies one command to the bench store. Returns 1 when the command is a
  // read, with the pixel value that the block must return in px.
  function automatic bit multilook_update(input pixel_cmd_t c, output pixel_result_t px);
    bit                  in_image;
    int                  col;
    int                  addr;
    logic [SUM_W:0]      total;
    logic [SUM_W-1:0]    mean;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   scaled;
    col      = int'($signed(c.column));
    in_image = (col >= 0) && (col < NUM_COLS) && (int'(c.row) < NUM_ROWS);
    addr     = in_image ? col * NUM_ROWS + int'(c.row) : 0;
    px       = '0;
    if (c.kind == KIND_ACC) begin
      // Samples outside the image are dropped without touching the store.
      if (in_image) begin
        if (c.row == '0 && look_cnt[col] != LOOKS_SAT) begin
          look_cnt[col] = look_cnt[col] + 1'b1;
        end
        total = {1'b0, pix_power[addr]} + (SUM_W+1)'(sample_power(c.re))
                + (SUM_W+1)'(sample_power(c.im));
        pix_power[addr] = (total > {1'b0, SUM_SAT}) ? SUM_SAT : total[SUM_W-1:0];
      end
      return 1'b0;
    end
    if (!in_image || look_cnt[col] == '0) begin
      px.no_looks = 1'b1;
      return 1'b1;
    end
    mean = pix_power[addr] / look_cnt[col];
    // Floor square root, one result bit at a time from the top.
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial    = root | (ROOT_W'(1) << b);
      trial_sq = trial * trial;
      if (trial_sq <= mean) begin
        root = trial;
      end
    end
    prod   = c.gain * root;
    scaled = prod >> FRAC_W;
    px.magnitude = (scaled > PROD_W'(MAG_SAT)) ? MAG_SAT : scaled[MAG_W-1:0];
    return 1'b1;
  endfunction

  function automatic int rand_sample();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom_range(0, 511) - 256;
    end
    return $urandom();
  endfunction

  // Column near the image in most cases, anywhere in the 16-bit range else.
  function automatic int stray_column();
    case ($urandom_range(0, 4))
      0: return -1;
      1: return NUM_COLS;
      2: return NUM_COLS + $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Well-formed looks in a quarter of the cases: a row-0 sample opens a look,
  // a few more rows of the same column follow, and a read of that column closes
  // it. Loose samples, loose reads and commands outside the image fill the rest.
  task automatic queue_mixed_traffic(input int target);
    int made;
    int sel;
    int col;
    int extra;
    made = 0;
    while (made < target) begin
      sel = $urandom_range(0, 99);
      col = $urandom_range(0, NUM_COLS - 1);
      if (sel < 12) begin
        pending_cmds.push_back(make_cmd(1'($urandom_range(0, 1)), stray_column(),
                                        $urandom_range(0, 255), rand_sample(),
                                        rand_sample(), $urandom()));
        made++;
      end else if (sel < 37) begin
        extra = $urandom_range(1, 3);
        pending_cmds.push_back(make_cmd(KIND_ACC, col, 0, rand_sample(), rand_sample(), 0));
        repeat (extra) begin
          pending_cmds.push_back(make_cmd(KIND_ACC, col, $urandom_range(0, 7),
                                          rand_sample(), rand_sample(), 0));
        end
        pending_cmds.push_back(make_cmd(KIND_READ, col, $urandom_range(0, 7), 0, 0,
                                        $urandom()));
        made += extra + 2;
      end else if (sel < 67) begin
        pending_cmds.push_back(make_cmd(KIND_ACC, col,
                                        ($urandom_range(0, 3) == 0) ? 0 :
                                        ($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                              : $urandom_range(0, 255)),
                                        rand_sample(), rand_sample(), $urandom()));
        made++;
      end else begin
        pending_cmds.push_back(make_cmd(KIND_READ, col,
                                        $urandom_range(0, 3) ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 255),
                                        rand_sample(), rand_sample(),
                                        $urandom_range(0, 4) ? $urandom() : GAIN_ONE));
        made++;
      end
    end
  endtask

  // Waits until every command is sent, every read has returned and the block is idle.
  task automatic drain_all();
    while (pending_cmds.size() != 0 || start || awaited_pixels.size() != 0 || busy) begin
      @(negedge clk_i);
    end
  endtask

  // Driver. A command is transferred at an edge where start is high and busy
  // is low; only then is the next one put on the ports, so start stays high
  // across back-to-back transfers.
  always @(posedge clk_i) begin : driver
    pixel_cmd_t    nxt;
    pixel_result_t px;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (multilook_update(make_cmd(kind_i, int'(column_i), int'(row_i),
                                      int'(sample_real_i), int'(sample_imag_i),
                                      int'(scallop_gain_i)), px)) begin
          awaited_pixels.push_back(px);
        end
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt            = pending_cmds.pop_front();
          start          <= 1'b1;
          kind_i         <= nxt.kind;
          column_i       <= nxt.column;
          row_i          <= nxt.row;
          sample_real_i  <= nxt.re;
          sample_imag_i  <= nxt.im;
          scallop_gain_i <= nxt.gain;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Results cannot be held off, so each strobe is taken at once.
  always @(posedge clk_i) begin : monitor
    pixel_result_t want;
    if (rst_ni && valid_o) begin
      if (awaited_pixels.size() == 0) begin
        flag_mismatch($sformatf("result with no read pending, magnitude %0d", magnitude_o));
      end else begin
        want = awaited_pixels.pop_front();
        if (magnitude_o !== want.magnitude) begin
          flag_mismatch($sformatf("magnitude %0d, predicted %0d",
                                  magnitude_o, want.magnitude));
        end
        if (no_looks_o !== want.no_looks) begin
          flag_mismatch($sformatf("no_looks %b, predicted %b", no_looks_o, want.no_looks));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_COLS * NUM_ROWS; i++) begin
      pix_power[i] = '0;
    end
    for (int i = 0; i < NUM_COLS; i++) begin
      look_cnt[i] = '0;
    end

    // Directed part. Reads of an empty store and of columns outside the
    // image, dropped samples, full-scale samples of both signs, a pixel with
    // looks but no power, and unity, zero and full gain.
    pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_READ, -1, 0, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS, 255, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, -32768, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_READ, 32767, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_ACC, -32768, 0, -32768, -32768, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, NUM_COLS, 0, 32767, 32767, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, 32767, 0, -32768, 32767, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, 0, 0, -32768, -32768, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, 0, 0, 32767, 32767, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, 0, 255, -32768, 32767, 0));
    pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, 0, 255, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_READ, 0, 1, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_ACC, NUM_COLS - 1, 0, -32768, -32768, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, NUM_COLS - 1, 0, -32768, -32768, 0));
    pending_cmds.push_back(make_cmd(KIND_ACC, NUM_COLS - 1, 0, -32768, -32768, 0));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, 1));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Light sender gaps.
    gap_pct = 11;
    drain_all();
    queue_mixed_traffic(420);
    drain_all();

    // Heavy sender gaps.
    gap_pct = 58;
    queue_mixed_traffic(420);
    drain_all();

    // Back to back. One pixel is driven with full-scale samples until both
    // its power sum and its column's look count saturate.
    gap_pct = 0;
    repeat (520) begin
      pending_cmds.push_back(make_cmd(KIND_ACC, NUM_COLS - 1, 0, -32768, -32768, 0));
    end
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, 'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, GAIN_ONE));
    pending_cmds.push_back(make_cmd(KIND_READ, NUM_COLS - 1, 0, 0, 0, $urandom()));
    queue_mixed_traffic(400);
    drain_all();

    repeat (SETTLE_CYC) @(negedge clk_i);
    if (mismatches == 0 && awaited_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
